FILE: rtl/checked_record_validator_defines.svh
// ----------------------------------------------------------------------------
// Checked record validator assertion macros
// Shared concurrent assertion forms for the validator RTL.
// ----------------------------------------------------------------------------
`ifndef CHECKED_RECORD_VALIDATOR_DEFINES_SVH
`define CHECKED_RECORD_VALIDATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CRV_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/crv_pkg.sv
// ----------------------------------------------------------------------------
// crv_pkg
// Types, constants and the CRC-32C byte step of the record validator.
// ----------------------------------------------------------------------------
package crv_pkg;

  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;
  localparam int unsigned CountW  = 33;
  localparam int unsigned LenSumW = 34;
  localparam int unsigned HdrLen  = 48;

  localparam logic [31:0] CrcPoly = 32'h82F6_3B78;
  localparam logic [7:0]  ByteMask = 8'hFF;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [2:0] REG_VERSION    = 3'd0;
  localparam logic [2:0] REG_TYPE_SET   = 3'd1;
  localparam logic [2:0] REG_TYPE_ERASE = 3'd2;
  localparam logic [2:0] REG_TYPE_CKPT  = 3'd3;
  localparam logic [2:0] REG_TYPE_CLEAR = 3'd4;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_VERSION  = 3'd2,
    ST_FRAMING  = 3'd3,
    ST_CHECKSUM = 3'd4,
    ST_TYPE     = 3'd5
  } crv_status_e;

  typedef struct packed {
    logic [7:0] version;
    logic [7:0] code_set;
    logic [7:0] code_erase;
    logic [7:0] code_ckpt;
    logic [7:0] code_clear;
  } crv_cfg_t;

  typedef struct packed {
    crv_status_e  status;
    logic [7:0]   kind;
    logic [63:0]  sequence_res;
    logic [63:0]  expiry;
    logic [7:0]   option_bits;
    logic [31:0]  shard;
    logic [31:0]  shard_total;
    logic [15:0]  space_length;
    logic [31:0]  key_length;
    logic [31:0]  value_length;
  } crv_result_t;

  // Reflected CRC-32C update by one byte.
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b & ByteMask};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CrcPoly ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/checked_record_validator.sv
// ----------------------------------------------------------------------------
// checked_record_validator
// Byte-stream record header parser with CRC-32C check and status result.
// ----------------------------------------------------------------------------
// The block takes one record byte per clock and keeps taking bytes while a
// finished result waits in the output register. Each byte passes an input
// register and then updates the byte count, the running CRC-32C (one byte step
// per cycle, from offset 4 on) and the header fields. The result of a record is
// valid on the output from the clock edge after its last byte is accepted, when
// the output register is free. A last byte can wait in the input register for a
// free output register, and the input is held off while it waits; other
// bytes never wait there. There is no clearing pass after reset.
// Configuration writes belong to idle periods.

module checked_record_validator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Input stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] data_byte
  input  logic                      s_axis_tlast,   // last
  // Output stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [7:0] record_kind, [71:8] sequence_res, [135:72] expiry, [143:136] option_bits,
  // [175:144] shard, [207:176] shard_total, [223:208] space_length,
  // [255:224] key_length, [287:256] value_length
  output logic [287:0]              m_axis_tdata,
  output logic [2:0]                m_axis_tuser,   // [2:0] status
  // Configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [crv_pkg::AddrW-1:0] paddr,
  input  logic [crv_pkg::DataW-1:0] pwdata,
  output logic [crv_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  crv_pkg::crv_cfg_t    cfg;
  crv_pkg::crv_result_t res;
  crv_pkg::crv_result_t out;
  logic                 res_valid;
  logic                 res_ready;

  crv_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  crv_rec_state u_rec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  crv_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_valid_o (m_axis_tvalid),
    .out_o       (out),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tuser = out.status;
  assign m_axis_tdata = {out.value_length, out.key_length, out.space_length,
                         out.shard_total, out.shard, out.option_bits,
                         out.expiry, out.sequence_res, out.kind};

endmodule

FILE: rtl/crv_cfg_regs.sv
// ----------------------------------------------------------------------------
// crv_cfg_regs
// APB register file holding the version and the four accepted type codes.
// ----------------------------------------------------------------------------
module crv_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [crv_pkg::AddrW-1:0] paddr,
  input  logic [crv_pkg::DataW-1:0] pwdata,
  output logic [crv_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output crv_pkg::crv_cfg_t         cfg_o
);

  crv_pkg::crv_cfg_t cfg_q;
  logic              wr_en;
  logic [2:0]        reg_idx;
  logic [7:0]        wr_byte;
  logic [7:0]        rd_byte;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign wr_byte = pwdata[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.version    <= 8'd1;
      cfg_q.code_set   <= 8'd0;
      cfg_q.code_erase <= 8'd1;
      cfg_q.code_ckpt  <= 8'd2;
      cfg_q.code_clear <= 8'd3;
    end else if (wr_en) begin
      unique case (reg_idx)
        crv_pkg::REG_VERSION:    cfg_q.version    <= wr_byte;
        crv_pkg::REG_TYPE_SET:   cfg_q.code_set   <= wr_byte;
        crv_pkg::REG_TYPE_ERASE: cfg_q.code_erase <= wr_byte;
        crv_pkg::REG_TYPE_CKPT:  cfg_q.code_ckpt  <= wr_byte;
        crv_pkg::REG_TYPE_CLEAR: cfg_q.code_clear <= wr_byte;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      crv_pkg::REG_VERSION:    rd_byte = cfg_q.version;
      crv_pkg::REG_TYPE_SET:   rd_byte = cfg_q.code_set;
      crv_pkg::REG_TYPE_ERASE: rd_byte = cfg_q.code_erase;
      crv_pkg::REG_TYPE_CKPT:  rd_byte = cfg_q.code_ckpt;
      crv_pkg::REG_TYPE_CLEAR: rd_byte = cfg_q.code_clear;
      default:                 rd_byte = 8'd0;
    endcase
  end

  assign prdata = {24'd0, rd_byte};
  assign cfg_o  = cfg_q;

endmodule

FILE: rtl/crv_rec_state.sv
// ----------------------------------------------------------------------------
// crv_rec_state
// Input register, record state (count, CRC, header fields) and status check.
// ----------------------------------------------------------------------------
`include "checked_record_validator_defines.svh"

module crv_rec_state (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [7:0]             in_byte_i,
  input  logic                   in_last_i,
  output logic                   in_ready_o,
  input  crv_pkg::crv_cfg_t      cfg_i,
  output logic                   res_valid_o,
  output crv_pkg::crv_result_t   res_o,
  input  logic                   res_ready_i
);

  localparam logic [crv_pkg::CountW-1:0] CntMax = '1;

  // Input register.
  logic       s1_valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       advance;

  // Record state.
  logic [crv_pkg::CountW-1:0]  count_q, count_d, count_nxt;
  logic [31:0]                 crc_q, crc_d, crc_nxt;
  logic [31:0]                 stored_q, stored_d;
  logic [7:0]                  version_q, version_d;
  logic [7:0]                  type_q, type_d;
  logic [15:0]                 space_q, space_d;
  logic [31:0]                 key_q, key_d;
  logic [31:0]                 value_q, value_d;
  logic [63:0]                 seq_q, seq_d;
  logic [63:0]                 expiry_q, expiry_d;
  logic [7:0]                  options_q, options_d;
  logic [63:0]                 shard_q, shard_d;
  logic [crv_pkg::LenSumW-1:0] len_sum_q;

  logic [5:0] off;
  logic [2:0] sh_off;
  logic       in_hdr;
  logic       type_hit;
  crv_pkg::crv_status_e status;

  assign advance     = s1_valid_q && (!last_q || res_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign res_valid_o = s1_valid_q && last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
  end

  assign count_nxt = (count_q == CntMax) ? count_q : count_q + 1'b1;
  assign crc_nxt   = (count_q >= crv_pkg::CountW'(4)) ? crv_pkg::crc32c_byte(crc_q, byte_q)
                                                      : crc_q;
  assign off       = count_q[5:0];
  assign in_hdr    = (count_q < crv_pkg::CountW'(crv_pkg::HdrLen));
  assign sh_off    = 3'(off - 6'd36);

  always_comb begin
    count_d   = count_q;
    crc_d     = crc_q;
    stored_d  = stored_q;
    version_d = version_q;
    type_d    = type_q;
    space_d   = space_q;
    key_d     = key_q;
    value_d   = value_q;
    seq_d     = seq_q;
    expiry_d  = expiry_q;
    options_d = options_q;
    shard_d   = shard_q;
    if (advance) begin
      if (last_q) begin
        count_d   = '0;
        crc_d     = '1;
        stored_d  = '0;
        version_d = '0;
        type_d    = '0;
        space_d   = '0;
        key_d     = '0;
        value_d   = '0;
        seq_d     = '0;
        expiry_d  = '0;
        options_d = '0;
        shard_d   = '0;
      end else begin
        count_d = count_nxt;
        crc_d   = crc_nxt;
        if (in_hdr) begin
          priority if (off < 6'd4) begin
            stored_d[{off[1:0], 3'b000} +: 8] = byte_q;
          end else if (off == 6'd4) begin
            version_d = byte_q;
          end else if (off == 6'd5) begin
            type_d = byte_q;
          end else if (off < 6'd8) begin
            space_d[{off[0], 3'b000} +: 8] = byte_q;
          end else if (off < 6'd12) begin
            key_d[{off[1:0], 3'b000} +: 8] = byte_q;
          end else if (off < 6'd16) begin
            value_d[{off[1:0], 3'b000} +: 8] = byte_q;
          end else if (off < 6'd24) begin
            seq_d[{off[2:0], 3'b000} +: 8] = byte_q;
          end else if (off < 6'd32) begin
            expiry_d[{off[2:0], 3'b000} +: 8] = byte_q;
          end else if (off == 6'd32) begin
            options_d = byte_q;
          end else if (off >= 6'd36 && off < 6'd44) begin
            shard_d[{sh_off, 3'b000} +: 8] = byte_q;
          end else begin
            // Reserved header bytes only feed the checksum.
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      crc_q     <= '1;
      stored_q  <= '0;
      version_q <= '0;
      type_q    <= '0;
      space_q   <= '0;
      key_q     <= '0;
      value_q   <= '0;
      seq_q     <= '0;
      expiry_q  <= '0;
      options_q <= '0;
      shard_q   <= '0;
    end else begin
      count_q   <= count_d;
      crc_q     <= crc_d;
      stored_q  <= stored_d;
      version_q <= version_d;
      type_q    <= type_d;
      space_q   <= space_d;
      key_q     <= key_d;
      value_q   <= value_d;
      seq_q     <= seq_d;
      expiry_q  <= expiry_d;
      options_q <= options_d;
      shard_q   <= shard_d;
    end
  end

  // The length fields settle by offset 15, long before a last byte at offset 47 or later
  // can be checked, so their sum is registered ahead of the frame compare.
  always_ff @(posedge clk_i) begin
    len_sum_q <= crv_pkg::LenSumW'(crv_pkg::HdrLen) + crv_pkg::LenSumW'(space_q)
               + crv_pkg::LenSumW'(key_q) + crv_pkg::LenSumW'(value_q);
  end

  assign type_hit = (type_q == cfg_i.code_set) || (type_q == cfg_i.code_erase) ||
                    (type_q == cfg_i.code_ckpt) || (type_q == cfg_i.code_clear);

  always_comb begin
    priority if (count_nxt < crv_pkg::CountW'(crv_pkg::HdrLen)) begin
      status = crv_pkg::ST_SHORT;
    end else if (version_q != cfg_i.version) begin
      status = crv_pkg::ST_VERSION;
    end else if (count_nxt[crv_pkg::CountW-1] ||
                 (len_sum_q != {1'b0, count_nxt})) begin
      status = crv_pkg::ST_FRAMING;
    end else if (~crc_nxt != stored_q) begin
      status = crv_pkg::ST_CHECKSUM;
    end else if (!type_hit) begin
      status = crv_pkg::ST_TYPE;
    end else begin
      status = crv_pkg::ST_OK;
    end
  end

  always_comb begin
    res_o        = '0;
    res_o.status = status;
    if (status == crv_pkg::ST_OK || status == crv_pkg::ST_TYPE) begin
      res_o.kind = type_q;
    end
    if (status == crv_pkg::ST_OK) begin
      res_o.sequence_res = seq_q;
      res_o.expiry       = expiry_q;
      res_o.option_bits  = options_q;
      res_o.shard        = shard_q[31:0];
      res_o.shard_total  = shard_q[63:32];
      res_o.space_length = space_q;
      res_o.key_length   = key_q;
      res_o.value_length = value_q;
    end
  end

  `CRV_ASSERT_NXT(a_clear_after_last, clk_i, rst_ni, advance && last_q,
    (count_q == '0) && (crc_q == '1) && (stored_q == '0), "record state not cleared after last byte")

  `CRV_ASSERT_NXT(a_hold_when_stalled, clk_i, rst_ni, s1_valid_q && !advance,
    s1_valid_q && $stable(byte_q) && $stable(last_q), "stalled byte lost from input register")

  `CRV_ASSERT_IMP(a_fields_zero_on_error, clk_i, rst_ni,
    res_valid_o && (res_o.status != crv_pkg::ST_OK) && (res_o.status != crv_pkg::ST_TYPE),
    (res_o.kind == 8'd0) && (res_o.sequence_res == 64'd0) && (res_o.key_length == 32'd0),
    "error result carries header fields")

endmodule

FILE: rtl/crv_out_reg.sv
// ----------------------------------------------------------------------------
// crv_out_reg
// Result register toward the output stream.
// ----------------------------------------------------------------------------
module crv_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 res_valid_i,
  input  crv_pkg::crv_result_t res_i,
  output logic                 res_ready_o,
  output logic                 out_valid_o,
  output crv_pkg::crv_result_t out_o,
  input  logic                 out_ready_i
);

  logic                 valid_q;
  crv_pkg::crv_result_t data_q;
  logic                 load;

  assign res_ready_o = !valid_q || out_ready_i;
  assign load        = res_valid_i && res_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule
